// ===== design/hmm_viterbi_decoder_top_macros.svh =====
// Assertion macros shared by the decoder's checking code.
`ifndef HMM_VITERBI_DECODER_TOP_MACROS_SVH
`define HMM_VITERBI_DECODER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define HVD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hvd assertion failed");

// Next-cycle implication, off during reset.
`define HVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hvd assertion failed");

`endif

// ===== design/hvd_pkg.sv =====
package hvd_pkg;

   localparam int NUM_STATES = 16;
   localparam int IDX_W      = $clog2(NUM_STATES);
   localparam int MAX_STEPS  = 64;
   localparam int STEP_W     = $clog2(MAX_STEPS + 1);
   localparam int T_W        = 6;
   localparam int SCORE_W    = 24;
   localparam int METRIC_W   = 32;
   localparam int CFG_W      = 5;
   localparam int SCAN_W     = IDX_W + 1;

   localparam logic [1:0] KIND_TRANS = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_OBS   = 2'd2;

   localparam logic [1:0] ADDR_STATES_IN_USE = 2'd0;

   typedef logic signed [METRIC_W-1:0] metric_type;
   typedef logic signed [SCORE_W-1:0]  score_type;

   localparam metric_type METRIC_MAX = {1'b0, {(METRIC_W-1){1'b1}}};
   localparam metric_type METRIC_MIN = {1'b1, {(METRIC_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       from_state;
      logic [3:0]       to_state;
      logic signed [23:0] score_value;
      logic             step_end;
      logic             sequence_end;
   } req_type;

   typedef struct packed {
      logic [5:0]         time_index;
      logic [3:0]         best_state;
      logic signed [31:0] log_likelihood;
      logic               truncated;
      logic               last_result;
   } rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic             wr_trans;
      logic             wr_start;
      logic             wr_msg;
      logic [IDX_W-1:0] wr_from;
      logic [IDX_W-1:0] wr_to;
      score_type        wr_score;
      metric_type       wr_msg_value;
      logic             seq_start;
      logic             commit;
      logic             clear;
   } cell_ctrl_type;

   // message travelling along the chain
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] src;
      metric_type       msg;
   } token_type;

   function automatic metric_type ext_score(input score_type s);
      ext_score = {{(METRIC_W-SCORE_W){s[SCORE_W-1]}}, s};
   endfunction

   function automatic metric_type sat_add(input metric_type a, input metric_type b);
      logic signed [METRIC_W:0] sum;
      sum = {a[METRIC_W-1], a} + {b[METRIC_W-1], b};
      if (sum[METRIC_W] != sum[METRIC_W-1]) begin
         sat_add = sum[METRIC_W] ? METRIC_MIN : METRIC_MAX;
      end else begin
         sat_add = sum[METRIC_W-1:0];
      end
   endfunction

endpackage

// ===== design/hvd_cell.sv =====
module hvd_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  hvd_pkg::cell_ctrl_type        ctrl,
   input  logic [hvd_pkg::IDX_W-1:0]     cell_index,
   input  logic                          active,
   input  hvd_pkg::token_type            tok_in,
   output hvd_pkg::token_type            tok_out,
   output hvd_pkg::metric_type           pm,
   output hvd_pkg::metric_type           msg,
   output logic [hvd_pkg::IDX_W-1:0]     arg
);
   import hvd_pkg::*;

   // column of the transition table that targets this state
   score_type        trans_ff [NUM_STATES];
   score_type        start_ff;
   metric_type       pm_ff, msg_ff, best_ff;
   logic [IDX_W-1:0] arg_ff;
   logic             tok_valid_ff;
   logic [IDX_W-1:0] tok_src_ff;
   metric_type       tok_msg_ff;

   metric_type cand;
   logic       take;

   // add-compare-select on the passing item
   always_comb begin
      cand = sat_add(tok_in.msg, ext_score(trans_ff[tok_in.src]));
      take = tok_in.valid && active &&
             ((cand > best_ff) || ((cand == best_ff) && (tok_in.src < arg_ff)));
   end

   // tables
   always_ff @(posedge clock) begin
      if (ctrl.wr_trans && (ctrl.wr_to == cell_index)) begin
         trans_ff[ctrl.wr_from] <= ctrl.wr_score;
      end
      if (ctrl.wr_start && (ctrl.wr_to == cell_index)) begin
         start_ff <= ctrl.wr_score;
      end
      tok_src_ff <= tok_in.src;
      tok_msg_ff <= tok_in.msg;
   end

   // metrics and running winner
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         pm_ff        <= '0;
         msg_ff       <= '0;
         best_ff      <= METRIC_MIN;
         arg_ff       <= '0;
      end else begin
         tok_valid_ff <= tok_in.valid;
         if (ctrl.seq_start) begin
            pm_ff <= ext_score(start_ff);
         end else if (ctrl.commit && active) begin
            pm_ff <= best_ff;
         end
         if (ctrl.wr_msg && (ctrl.wr_to == cell_index)) begin
            msg_ff <= ctrl.wr_msg_value;
         end
         if (ctrl.clear) begin
            best_ff <= METRIC_MIN;
            arg_ff  <= '0;
         end else if (take) begin
            best_ff <= cand;
            arg_ff  <= tok_in.src;
         end
      end
   end

   assign tok_out.valid = tok_valid_ff;
   assign tok_out.src   = tok_src_ff;
   assign tok_out.msg   = tok_msg_ff;
   assign pm            = pm_ff;
   assign msg           = msg_ff;
   assign arg           = arg_ff;

endmodule

// ===== design/hmm_viterbi_decoder_top.sv =====
// Log-domain HMM Viterbi decoder. Load items (transition and start scores) are written
// into the cells on acceptance. An observation item has its message formed, then walks
// the row of 16 add-compare-select cells one cell per cycle; a step-end item adds a commit.
// On sequence end the block scans the messages (one state per cycle), traces back through
// the stored steps (a path write, then a back-pointer load, per step) and emits results
// (a path read, then an output load, per result), all before the next item is taken.
// Results wait in an output register; the input is stalled while an item is at work.
module hmm_viterbi_decoder_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hvd_pkg::req_type     req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hvd_pkg::rsp_type     rsp_payload,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [1:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import hvd_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MSG    = 9'b000000010,
      ST_CHAIN  = 9'b000000100,
      ST_COMMIT = 9'b000001000,
      ST_FIN    = 9'b000010000,
      ST_SCAN   = 9'b000100000,
      ST_TB_WR  = 9'b001000000,
      ST_TB_LD  = 9'b010000000,
      ST_EM_RD  = 9'b100000000
   } state_type;
   // emit-load has no state of its own: a flag marks it while the state stays IDLE
   state_type state_ff, state_in;

   logic [CFG_W-1:0]  states_ff;
   logic [CFG_W-1:0]  s_act;
   req_type           item_ff;
   logic              in_seq_ff, ovf_ff, em_ld_ff;
   logic [STEP_W-1:0] step_cnt_ff;
   logic [SCAN_W-1:0] k_ff;
   metric_type        sbest_ff;
   logic [IDX_W-1:0]  sarg_ff, cur_ff;
   logic [T_W-1:0]    t_ff, last_t_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [NUM_STATES*IDX_W-1:0] bp_mem [MAX_STEPS];
   logic [NUM_STATES*IDX_W-1:0] bp_rd_ff;
   logic [IDX_W-1:0]            dp_mem [MAX_STEPS];
   logic [IDX_W-1:0]            dp_rd_ff;

   cell_ctrl_type    ctrl;
   token_type        tok [NUM_STATES+1];
   metric_type       pm_w  [NUM_STATES];
   metric_type       msg_w [NUM_STATES];
   logic [IDX_W-1:0] arg_w [NUM_STATES];
   logic [NUM_STATES-1:0] active;

   logic req_acc, rsp_acc, full, out_free;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_STATES_IN_USE) ?
                       {{(32-CFG_W){1'b0}}, states_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff <= CFG_W'(NUM_STATES);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == ADDR_STATES_IN_USE)) begin
         states_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      if (states_ff == '0) begin
         s_act = CFG_W'(1);
      end else if (states_ff > CFG_W'(NUM_STATES)) begin
         s_act = CFG_W'(NUM_STATES);
      end else begin
         s_act = states_ff;
      end
      for (int j = 0; j < NUM_STATES; j++) begin
         active[j] = CFG_W'(j) < s_act;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || em_ld_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = step_cnt_ff >= STEP_W'(MAX_STEPS);

   // cell control
   always_comb begin
      ctrl = '0;
      ctrl.wr_from  = req_payload.from_state;
      ctrl.wr_to    = req_acc ? req_payload.to_state : item_ff.to_state;
      ctrl.wr_score = req_payload.score_value;
      ctrl.wr_msg_value = sat_add(pm_w[item_ff.to_state], ext_score(item_ff.score_value));
      tok[0] = '0;
      tok[0].src = item_ff.to_state;
      tok[0].msg = ctrl.wr_msg_value;
      if (req_acc) begin
         ctrl.wr_trans  = req_payload.kind == KIND_TRANS;
         ctrl.wr_start  = req_payload.kind == KIND_START;
         ctrl.seq_start = (req_payload.kind == KIND_OBS) && !in_seq_ff;
      end
      if ((state_ff == ST_MSG) && !full && (CFG_W'(item_ff.to_state) < s_act)) begin
         ctrl.wr_msg  = 1'b1;
         tok[0].valid = 1'b1;
      end
      if (state_ff == ST_COMMIT) begin
         ctrl.commit = 1'b1;
         ctrl.clear  = 1'b1;
      end
      if ((state_ff == ST_FIN) && (step_cnt_ff == '0)) begin
         ctrl.clear = 1'b1;
      end
      if (em_ld_ff && out_free && (t_ff == last_t_ff)) begin
         ctrl.clear = 1'b1;
      end
   end

   // row of cells
   for (genvar j = 0; j < NUM_STATES; j++) begin : g_cell
      hvd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(j)),
         .active     (active[j]),
         .tok_in     (tok[j]),
         .tok_out    (tok[j+1]),
         .pm         (pm_w[j]),
         .msg        (msg_w[j]),
         .arg        (arg_w[j])
      );
   end

   // back-pointer rows and decoded path
   always_ff @(posedge clock) begin
      if (state_ff == ST_COMMIT) begin
         for (int j = 0; j < NUM_STATES; j++) begin
            if (active[j]) begin
               bp_mem[step_cnt_ff[T_W-1:0]][j*IDX_W +: IDX_W] <= arg_w[j];
            end
         end
      end
      bp_rd_ff <= bp_mem[t_ff - T_W'(1)];
      if (state_ff == ST_TB_WR) begin
         dp_mem[t_ff] <= cur_ff;
      end
      dp_rd_ff <= dp_mem[t_ff];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_payload.kind == KIND_OBS)) state_in = ST_MSG;
         end
         ST_MSG: begin
            if (full) begin
               state_in = (item_ff.step_end && item_ff.sequence_end) ? ST_FIN : ST_IDLE;
            end else if (CFG_W'(item_ff.to_state) < s_act) begin
               state_in = ST_CHAIN;
            end else begin
               state_in = item_ff.step_end ? ST_COMMIT : ST_IDLE;
            end
         end
         ST_CHAIN: begin
            if (tok[NUM_STATES].valid) begin
               state_in = item_ff.step_end ? ST_COMMIT : ST_IDLE;
            end
         end
         ST_COMMIT: state_in = item_ff.sequence_end ? ST_FIN : ST_IDLE;
         ST_FIN:    state_in = (step_cnt_ff == '0) ? ST_IDLE : ST_SCAN;
         ST_SCAN: begin
            if (k_ff >= s_act) state_in = ST_TB_WR;
         end
         ST_TB_WR:  state_in = (t_ff == '0) ? ST_EM_RD : ST_TB_LD;
         ST_TB_LD:  state_in = ST_TB_WR;
         ST_EM_RD:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      // emit load holds the sequencer in IDLE code with em_ld_ff raised
      if (em_ld_ff) begin
         state_in = (out_free && (t_ff == last_t_ff)) ? ST_IDLE :
                    (out_free ? ST_EM_RD : ST_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         em_ld_ff     <= 1'b0;
         in_seq_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         em_ld_ff <= (state_ff == ST_EM_RD) || (em_ld_ff && !out_free);
         if (ctrl.seq_start) in_seq_ff <= 1'b1;
         if ((state_ff == ST_MSG) && full) ovf_ff <= 1'b1;
         if (state_ff == ST_COMMIT) step_cnt_ff <= step_cnt_ff + STEP_W'(1);
         if ((state_ff == ST_FIN) && (step_cnt_ff == '0)) begin
            in_seq_ff <= 1'b0;
            ovf_ff    <= 1'b0;
         end
         // a new result replaces one taken in the same cycle
         if (em_ld_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (t_ff == last_t_ff) begin
               in_seq_ff   <= 1'b0;
               ovf_ff      <= 1'b0;
               step_cnt_ff <= '0;
            end
         end else if (rsp_acc) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers of the sequencer
   always_ff @(posedge clock) begin
      if (req_acc) item_ff <= req_payload;
      case (state_ff)
         ST_FIN: begin
            k_ff      <= SCAN_W'(1);
            sbest_ff  <= msg_w[0];
            sarg_ff   <= '0;
            last_t_ff <= T_W'(step_cnt_ff - STEP_W'(1));
         end
         ST_SCAN: begin
            if (k_ff < s_act) begin
               if (msg_w[k_ff[IDX_W-1:0]] > sbest_ff) begin
                  sbest_ff <= msg_w[k_ff[IDX_W-1:0]];
                  sarg_ff  <= k_ff[IDX_W-1:0];
               end
               k_ff <= k_ff + SCAN_W'(1);
            end else begin
               cur_ff <= sarg_ff;
               t_ff   <= last_t_ff;
            end
         end
         ST_TB_LD: begin
            cur_ff <= bp_rd_ff[cur_ff*IDX_W +: IDX_W];
            t_ff   <= t_ff - T_W'(1);
         end
         default: begin
         end
      endcase
      if (em_ld_ff && out_free) begin
         rsp_ff.time_index     <= t_ff;
         rsp_ff.best_state     <= dp_rd_ff;
         rsp_ff.log_likelihood <= sbest_ff;
         rsp_ff.truncated      <= ovf_ff;
         rsp_ff.last_result    <= t_ff == last_t_ff;
         if (t_ff != last_t_ff) t_ff <= t_ff + T_W'(1);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `include "hmm_viterbi_decoder_top_macros.svh"

   `HVD_ASSERT_NEXT(a_obs_busy, clock, reset, req_acc && (req_payload.kind == KIND_OBS), state_ff == ST_MSG)
   `HVD_ASSERT_NEXT(a_last_drains, clock, reset, rsp_acc && rsp_ff.last_result, !rsp_valid_ff)
   `HVD_ASSERT_NOW(a_step_range, clock, reset, 1'b1, step_cnt_ff <= STEP_W'(MAX_STEPS))

endmodule
